/* src/ecgp_pkg.sv */
// ----------------------------------------------------------------------------
// ecgp_pkg
// Shared types and constants for the ECG FIFO status and sample parser.
// ----------------------------------------------------------------------------
package ecgp_pkg;

    localparam int WORD_W   = 24;
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 32;
    localparam int POS_W    = 6;
    localparam int TAG_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam int BURST_WORDS_DEF = 8;

    localparam logic [WORD_W-1:0] DATA_READY_MASK_RST = 24'h800000;
    localparam logic [WORD_W-1:0] OVERFLOW_MASK_RST   = 24'h400000;
    localparam logic [WORD_W-1:0] PLL_UNLOCK_MASK_RST = 24'h000100;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_READY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLL_UNLOCK = 2'd2;

    // FIFO word tags, bits 5..3; tags 4 and 5 are unknown
    localparam logic [TAG_W-1:0] TAG_VALID     = 3'd0;
    localparam logic [TAG_W-1:0] TAG_FAST      = 3'd1;
    localparam logic [TAG_W-1:0] TAG_VALID_EOF = 3'd2;
    localparam logic [TAG_W-1:0] TAG_FAST_EOF  = 3'd3;
    localparam logic [TAG_W-1:0] TAG_EMPTY     = 3'd6;
    localparam logic [TAG_W-1:0] TAG_OVERFLOW  = 3'd7;

    typedef enum logic [1:0] {
        ACT_NEXT_WORD = 2'd0,
        ACT_STATUS    = 2'd1,
        ACT_STOP      = 2'd2,
        ACT_RESET     = 2'd3
    } t_action;

    typedef struct packed {
        logic samples;
        logic overflows;
        logic empties;
        logic tag_overflows;
        logic pll_seen;
        logic pll_edges;
    } t_cnt_inc;

    typedef struct packed {
        logic             pll_prev;
        logic [POS_W-1:0] pos;
        logic             skipping;
    } t_burst_state;

    typedef struct packed {
        logic [WORD_W-1:0] data_ready;
        logic [WORD_W-1:0] overflow;
        logic [WORD_W-1:0] pll_unlock;
    } t_masks;

endpackage

/* src/ecg_fifo_status_and_sample_parser.sv */
// ----------------------------------------------------------------------------
// ecg_fifo_status_and_sample_parser
// An accepted word sits in the input register, then is decoded into the
// result register and counter bank once the result stage is free.
// Throughput: one word per cycle while i_ready is high; the single decode
// stage sets the rate.
// Reset: synchronous, active low; clears counters, burst state and pipeline
// valids and restores the default status masks.
// ----------------------------------------------------------------------------
module ecg_fifo_status_and_sample_parser import ecgp_pkg::*; #(
    parameter int BURST_WORDS = BURST_WORDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [WORD_W-1:0]          i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_mode,
    input  logic [WORD_W-1:0]          i_word,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_sample_valid,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic [1:0]                 o_next_action,
    output logic [CNT_W-1:0]           o_samples_total,
    output logic [CNT_W-1:0]           o_overflows_total,
    output logic [CNT_W-1:0]           o_empties_total,
    output logic [CNT_W-1:0]           o_tag_overflows_total,
    output logic [CNT_W-1:0]           o_pll_seen_total,
    output logic [CNT_W-1:0]           o_pll_edges_total
);

    t_masks                     r_masks;
    logic                       r_in_valid;
    logic                       r_mode;
    logic [WORD_W-1:0]          r_word;
    t_burst_state               r_state;
    t_burst_state               n_state;
    t_cnt_inc                   n_inc;
    logic                       n_sample_valid;
    logic signed [SAMPLE_W-1:0] n_sample;
    t_action                    n_action;
    logic                       r_out_valid;
    logic                       r_sample_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    t_action                    r_action;
    logic                       adv;

    // move the held word into the result stage once that stage is free
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks.data_ready <= DATA_READY_MASK_RST;
            r_masks.overflow   <= OVERFLOW_MASK_RST;
            r_masks.pll_unlock <= PLL_UNLOCK_MASK_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_DATA_READY: r_masks.data_ready <= i_cfg_wdata;
                CFG_OVERFLOW:   r_masks.overflow   <= i_cfg_wdata;
                CFG_PLL_UNLOCK: r_masks.pll_unlock <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode <= i_mode;
            r_word <= i_word;
        end
    end

    ecgp_decode #(
        .BURST_WORDS (BURST_WORDS)
    ) u_decode (
        .i_mode         (r_mode),
        .i_word         (r_word),
        .i_masks        (r_masks),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_inc          (n_inc),
        .o_sample_valid (n_sample_valid),
        .o_sample       (n_sample),
        .o_action       (n_action)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_state <= n_state;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sample_valid <= n_sample_valid;
            r_sample       <= n_sample;
            r_action       <= n_action;
        end
    end

    // counters only move with a load, so they stay matched to the held result
    ecgp_counters u_counters (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (adv),
        .i_inc           (n_inc),
        .o_samples       (o_samples_total),
        .o_overflows     (o_overflows_total),
        .o_empties       (o_empties_total),
        .o_tag_overflows (o_tag_overflows_total),
        .o_pll_seen      (o_pll_seen_total),
        .o_pll_edges     (o_pll_edges_total)
    );

    assign o_valid        = r_out_valid;
    assign o_sample_valid = r_sample_valid;
    assign o_sample       = r_sample;
    assign o_next_action  = r_action;

    a_pos_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos < POS_W'(BURST_WORDS))
        else $error("burst position beyond burst length");

    a_sample_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_samples_total == $past(o_samples_total) + CNT_W'(o_sample_valid))
        else $error("sample count out of step with delivered samples");

    a_counters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(o_overflows_total) && $stable(o_pll_seen_total))
        else $error("counter moved without a loaded result");

    a_no_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sample_valid |-> o_sample == '0)
        else $error("sample not cleared on a result without a sample");

endmodule

/* src/ecgp_decode.sv */
// ----------------------------------------------------------------------------
// ecgp_decode
// Decodes one status or FIFO word against the current burst state.
// ----------------------------------------------------------------------------
module ecgp_decode import ecgp_pkg::*; #(
    parameter int BURST_WORDS = BURST_WORDS_DEF
) (
    input  logic                       i_mode,
    input  logic [WORD_W-1:0]          i_word,
    input  t_masks                     i_masks,
    input  t_burst_state               i_state,
    output t_burst_state               o_state,
    output t_cnt_inc                   o_inc,
    output logic                       o_sample_valid,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output t_action                    o_action
);

    logic [POS_W-1:0] pos_inc;
    logic             last;
    logic             pll_flag;
    logic [TAG_W-1:0] tag;

    assign pos_inc  = i_state.pos + POS_W'(1);
    assign last     = (pos_inc >= POS_W'(BURST_WORDS));
    assign pll_flag = |(i_word & i_masks.pll_unlock);
    assign tag      = i_word[5:3];

    always_comb begin
        o_state        = i_state;
        o_inc          = '0;
        o_sample_valid = 1'b0;
        o_sample       = '0;
        o_action       = ACT_STATUS;

        if (!i_mode) begin
            o_inc.pll_seen   = pll_flag;
            o_inc.pll_edges  = pll_flag && !i_state.pll_prev;
            o_state.pll_prev = pll_flag;
            o_state.pos      = '0;
            o_state.skipping = 1'b0;
            if (|(i_word & i_masks.overflow)) begin
                o_inc.overflows = 1'b1;
                o_action        = ACT_RESET;
            end else if (!(|(i_word & i_masks.data_ready))) begin
                o_action = ACT_STOP;
            end else begin
                o_action = ACT_NEXT_WORD;
            end
        end else begin
            // count the word into the burst; wrap the burst when complete
            o_state.pos = last ? '0 : pos_inc;
            if (last) begin
                o_state.skipping = 1'b0;
            end
            if (!i_state.skipping) begin
                case (tag)
                    TAG_VALID, TAG_FAST: begin
                        o_action = last ? ACT_STATUS : ACT_NEXT_WORD;
                    end
                    TAG_OVERFLOW: begin
                        o_inc.tag_overflows = 1'b1;
                        o_inc.overflows     = 1'b1;
                        o_state.skipping    = !last;
                        o_action            = ACT_RESET;
                    end
                    default: begin
                        o_inc.empties    = (tag == TAG_EMPTY);
                        o_state.skipping = !last;
                        o_action         = ACT_STATUS;
                    end
                endcase
                if (tag == TAG_VALID || tag == TAG_VALID_EOF) begin
                    o_sample_valid = 1'b1;
                    o_sample       = i_word[23:8];
                    o_inc.samples  = 1'b1;
                end
            end
        end
    end

endmodule

/* src/ecgp_counters.sv */
// ----------------------------------------------------------------------------
// ecgp_counters
// Bank of six wrapping 32-bit event counters.
// ----------------------------------------------------------------------------
module ecgp_counters import ecgp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_cnt_inc         i_inc,
    output logic [CNT_W-1:0] o_samples,
    output logic [CNT_W-1:0] o_overflows,
    output logic [CNT_W-1:0] o_empties,
    output logic [CNT_W-1:0] o_tag_overflows,
    output logic [CNT_W-1:0] o_pll_seen,
    output logic [CNT_W-1:0] o_pll_edges
);

    logic [CNT_W-1:0] r_samples, r_overflows, r_empties;
    logic [CNT_W-1:0] r_tag_overflows, r_pll_seen, r_pll_edges;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples       <= '0;
            r_overflows     <= '0;
            r_empties       <= '0;
            r_tag_overflows <= '0;
            r_pll_seen      <= '0;
            r_pll_edges     <= '0;
        end else if (i_en) begin
            r_samples       <= r_samples       + CNT_W'(i_inc.samples);
            r_overflows     <= r_overflows     + CNT_W'(i_inc.overflows);
            r_empties       <= r_empties       + CNT_W'(i_inc.empties);
            r_tag_overflows <= r_tag_overflows + CNT_W'(i_inc.tag_overflows);
            r_pll_seen      <= r_pll_seen      + CNT_W'(i_inc.pll_seen);
            r_pll_edges     <= r_pll_edges     + CNT_W'(i_inc.pll_edges);
        end
    end

    assign o_samples       = r_samples;
    assign o_overflows     = r_overflows;
    assign o_empties       = r_empties;
    assign o_tag_overflows = r_tag_overflows;
    assign o_pll_seen      = r_pll_seen;
    assign o_pll_edges     = r_pll_edges;

endmodule
